FILE: rtl/smra_pkg.sv
// ----------------------------------------------------------------------------
// SPI register access package
// Request and result payload types, command codes and sequencer phases.
// ----------------------------------------------------------------------------
package smra_pkg;

	localparam logic [2:0] MODE_NONE        = 3'd0;
	localparam logic [2:0] MODE_BEGIN_WRITE = 3'd1;
	localparam logic [2:0] MODE_BEGIN_READ  = 3'd2;
	localparam logic [2:0] MODE_WRITE_BYTE  = 3'd3;
	localparam logic [2:0] MODE_READ_BYTE   = 3'd4;
	localparam logic [2:0] MODE_WRITE_WORD  = 3'd5;
	localparam logic [2:0] MODE_READ_WORD   = 3'd6;
	localparam logic [2:0] MODE_END         = 3'd7;

	localparam logic [7:0] ADDR_WRITE_FLAG = 8'h80;
	localparam int unsigned BYTE_BITS      = 8;

	typedef enum logic [2:0] {
		PH_IDLE = 3'b001,
		PH_HIGH = 3'b010,
		PH_LOW  = 3'b100
	} phase_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [6:0]  reg_address;
		logic [15:0] write_data;
		logic        miso_level;
	} req_t;

	typedef struct packed {
		logic        chip_select_n;
		logic        serial_clock;
		logic        master_out;
		logic        ready_res;
		logic [15:0] read_data;
		logic        read_valid;
	} res_t;

endpackage

FILE: rtl/smra_req_if.sv
// ----------------------------------------------------------------------------
// SPI register access request channel
// Valid/ready channel carrying one request per tick.
// ----------------------------------------------------------------------------
interface smra_req_if import smra_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/smra_res_if.sv
// ----------------------------------------------------------------------------
// SPI register access result channel
// Valid/ready channel carrying pin levels and read data per tick.
// ----------------------------------------------------------------------------
interface smra_res_if import smra_pkg::*; ();
	logic valid;
	logic ready;
	res_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/spi_master_register_access_core.sv
// ----------------------------------------------------------------------------
// SPI master register access core
// Mode 0, MSB first SPI master stepped by one request per tick.
// Each request is captured in the input register, and its result is then registered in the output register.
// Throughput: one request per cycle while results are taken; the pin sequencer updates once per request.
// A held result stalls the input register, which stalls the request channel.
// Reset: CS high, SCK and MOSI low, sequencer idle, half period of one tick.
// ----------------------------------------------------------------------------
module spi_master_register_access_core import smra_pkg::*; #(
	parameter int unsigned WORD_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	smra_req_if.sink   req,
	smra_res_if.source res
);

	localparam int unsigned BL_W = $clog2(WORD_BITS + 1);

	logic [7:0]           half_q;
	logic                 valid_s1;
	req_t                 req_s1;
	logic                 res_valid_q;
	res_t                 res_q;
	phase_t               phase_q;
	logic [WORD_BITS-1:0] shift_q;
	logic [BL_W-1:0]      bits_q;
	logic [7:0]           tick_q;
	logic                 cs_q;
	logic                 sck_q;
	logic                 mosi_q;
	logic                 rd_q;

	phase_t               phase_d;
	logic [WORD_BITS-1:0] shift_d;
	logic [BL_W-1:0]      bits_d;
	logic [7:0]           tick_d;
	logic                 cs_d;
	logic                 sck_d;
	logic                 mosi_d;
	logic                 rd_d;
	logic [15:0]          rdata_d;
	logic                 rvalid_d;
	logic [7:0]           half_len;
	logic                 half_done;
	logic                 adv;
	logic                 start;
	logic [WORD_BITS-1:0] load_val;
	logic [BL_W-1:0]      load_bits;
	logic                 load_rd;
	logic [WORD_BITS-1:0] shift_nx;
	logic [BL_W-1:0]      bits_nx;

	assign adv       = valid_s1 && (!res_valid_q || res.ready);
	assign req.ready = !valid_s1 || adv;
	assign res.valid = res_valid_q;
	assign res.data  = res_q;

	assign half_len  = (half_q == 8'd0) ? 8'd1 : half_q;
	assign half_done = tick_q >= half_len;
	assign shift_nx  = {shift_q[WORD_BITS-2:0], rd_q ? req_s1.miso_level : 1'b0};
	assign bits_nx   = bits_q - BL_W'(1);

	always_comb begin
		start     = 1'b0;
		load_val  = '0;
		load_bits = BL_W'(BYTE_BITS);
		load_rd   = 1'b0;
		case (req_s1.mode)
			MODE_BEGIN_WRITE: begin
				start    = 1'b1;
				load_val = WORD_BITS'(ADDR_WRITE_FLAG | {1'b0, req_s1.reg_address})
					<< (WORD_BITS - BYTE_BITS);
			end
			MODE_BEGIN_READ: begin
				start    = 1'b1;
				load_val = WORD_BITS'({1'b0, req_s1.reg_address}) << (WORD_BITS - BYTE_BITS);
			end
			MODE_WRITE_BYTE: begin
				start    = 1'b1;
				load_val = WORD_BITS'(req_s1.write_data[7:0]) << (WORD_BITS - BYTE_BITS);
			end
			MODE_READ_BYTE: begin
				start   = 1'b1;
				load_rd = 1'b1;
			end
			MODE_WRITE_WORD: begin
				start     = 1'b1;
				load_val  = WORD_BITS'(req_s1.write_data);
				load_bits = BL_W'(WORD_BITS);
			end
			MODE_READ_WORD: begin
				start     = 1'b1;
				load_rd   = 1'b1;
				load_bits = BL_W'(WORD_BITS);
			end
			default: begin
				start = 1'b0;
			end
		endcase
	end

	always_comb begin
		phase_d  = phase_q;
		shift_d  = shift_q;
		bits_d   = bits_q;
		tick_d   = tick_q;
		cs_d     = cs_q;
		sck_d    = sck_q;
		mosi_d   = mosi_q;
		rd_d     = rd_q;
		rdata_d  = '0;
		rvalid_d = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (req_s1.mode == MODE_BEGIN_WRITE || req_s1.mode == MODE_BEGIN_READ) begin
					cs_d = 1'b0;
				end else if (req_s1.mode == MODE_END) begin
					cs_d = 1'b1;
				end
				if (start) begin
					shift_d = load_val;
					bits_d  = load_bits;
					rd_d    = load_rd;
					if (!load_rd) begin
						mosi_d = load_val[WORD_BITS-1];
					end
					sck_d   = 1'b1;
					tick_d  = 8'd1;
					phase_d = PH_HIGH;
				end
			end
			PH_HIGH: begin
				if (half_done) begin
					sck_d   = 1'b0;
					tick_d  = 8'd1;
					phase_d = PH_LOW;
				end else begin
					tick_d = tick_q + 8'd1;
				end
			end
			PH_LOW: begin
				if (half_done) begin
					shift_d = shift_nx;
					bits_d  = bits_nx;
					if (bits_nx == '0) begin
						phase_d  = PH_IDLE;
						tick_d   = 8'd0;
						rvalid_d = rd_q;
						rdata_d  = rd_q ? 16'(shift_nx) : 16'd0;
					end else begin
						if (!rd_q) begin
							mosi_d = shift_nx[WORD_BITS-1];
						end
						sck_d   = 1'b1;
						tick_d  = 8'd1;
						phase_d = PH_HIGH;
					end
				end else begin
					tick_d = tick_q + 8'd1;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q      <= 8'd1;
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
			phase_q     <= PH_IDLE;
			shift_q     <= '0;
			bits_q      <= '0;
			tick_q      <= 8'd0;
			cs_q        <= 1'b1;
			sck_q       <= 1'b0;
			mosi_q      <= 1'b0;
			rd_q        <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				half_q <= cfg_wr_data;
			end
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (adv) begin
				res_valid_q <= 1'b1;
				phase_q     <= phase_d;
				shift_q     <= shift_d;
				bits_q      <= bits_d;
				tick_q      <= tick_d;
				cs_q        <= cs_d;
				sck_q       <= sck_d;
				mosi_q      <= mosi_d;
				rd_q        <= rd_d;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_s1 <= req.data;
		end
		if (adv) begin
			res_q.chip_select_n <= cs_d;
			res_q.serial_clock  <= sck_d;
			res_q.master_out    <= mosi_d;
			res_q.ready_res     <= (phase_d == PH_IDLE);
			res_q.read_data     <= rdata_d;
			res_q.read_valid    <= rvalid_d;
		end
	end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI register access core testbench
// Steps the core one request per tick and checks every result for pin levels,
// ready and read data against a cycle-level model of the SPI sequencer kept
// by a scoreboard. Runs directed transactions, then random transaction
// streams over several SCK half periods, with random sender gaps and
// receiver stalls.
// ----------------------------------------------------------------------------
module tb;
	import smra_pkg::*;

	localparam int WORD_BITS   = 16;
	localparam int STALL_LIMIT = 5000;
	localparam int LONG_HOLD   = 400;

	typedef enum {MISO_LOW, MISO_HIGH, MISO_RANDOM} miso_drive_t;

	class pin_tracker #(int WORD_LEN = 16);
		phase_t      seq_phase;
		logic [31:0] shifter;
		int          bits_left;
		int          ticks;
		logic        cs_n;
		logic        sck;
		logic        mosi;
		logic        reading;
		logic [7:0]  half;
		res_t        pins_due[$];
		int          errors;

		function new();
			seq_phase = PH_IDLE;
			shifter   = '0;
			bits_left = 0;
			ticks     = 0;
			cs_n      = 1'b1;
			sck       = 1'b0;
			mosi      = 1'b0;
			reading   = 1'b0;
			half      = 8'd1;
			errors    = 0;
		endfunction

		function int half_len();
			return (half == 8'd0) ? 1 : int'(half);
		endfunction

		function bit idle();
			return seq_phase == PH_IDLE;
		endfunction

		function int pending();
			return pins_due.size();
		endfunction

		function void next_bit();
			if (!reading) begin
				mosi = shifter[bits_left - 1];
			end
			sck       = 1'b1;
			ticks     = 1;
			seq_phase = PH_HIGH;
		endfunction

		function void load(logic [31:0] value, int nbits, logic rd);
			shifter   = rd ? '0 : value;
			bits_left = nbits;
			reading   = rd;
			next_bit();
		endfunction

		function void note_request(req_t r);
			res_t due;
			due = '0;
			case (seq_phase)
				PH_IDLE: begin
					case (r.mode)
						MODE_BEGIN_WRITE: begin
							cs_n = 1'b0;
							load(32'(ADDR_WRITE_FLAG | 8'(r.reg_address)), BYTE_BITS, 1'b0);
						end
						MODE_BEGIN_READ: begin
							cs_n = 1'b0;
							load(32'(r.reg_address), BYTE_BITS, 1'b0);
						end
						MODE_WRITE_BYTE: load(32'(r.write_data[7:0]), BYTE_BITS, 1'b0);
						MODE_READ_BYTE:  load('0, BYTE_BITS, 1'b1);
						MODE_WRITE_WORD: load(32'(r.write_data), WORD_LEN, 1'b0);
						MODE_READ_WORD:  load('0, WORD_LEN, 1'b1);
						MODE_END:        cs_n = 1'b1;
						default: ;
					endcase
				end
				PH_HIGH: begin
					if (ticks >= half_len()) begin
						sck       = 1'b0;
						ticks     = 1;
						seq_phase = PH_LOW;
					end else begin
						ticks++;
					end
				end
				default: begin
					if (ticks >= half_len()) begin
						if (reading) begin
							shifter = {shifter[30:0], r.miso_level};
						end
						bits_left--;
						if (bits_left == 0) begin
							seq_phase = PH_IDLE;
							ticks     = 0;
							if (reading) begin
								due.read_valid = 1'b1;
								due.read_data  = shifter[15:0];
							end
						end else begin
							next_bit();
						end
					end else begin
						ticks++;
					end
				end
			endcase
			due.chip_select_n = cs_n;
			due.serial_clock  = sck;
			due.master_out    = mosi;
			due.ready_res     = (seq_phase == PH_IDLE);
			pins_due.push_back(due);
		endfunction

		function void compare_field(string field, logic [15:0] want, logic [15:0] seen);
			if (seen !== want) begin
				$error("%s: expected %0h, got %0h", field, want, seen);
				errors++;
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (pins_due.size() == 0) begin
				$error("result with no request pending");
				errors++;
				return;
			end
			want = pins_due.pop_front();
			compare_field("chip_select_n", 16'(want.chip_select_n), 16'(got.chip_select_n));
			compare_field("serial_clock", 16'(want.serial_clock), 16'(got.serial_clock));
			compare_field("master_out", 16'(want.master_out), 16'(got.master_out));
			compare_field("ready_res", 16'(want.ready_res), 16'(got.ready_res));
			compare_field("read_data", want.read_data, got.read_data);
			compare_field("read_valid", 16'(want.read_valid), 16'(got.read_valid));
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [7:0] cfg_wr_data;

	smra_req_if req_ch();
	smra_res_if res_ch();

	pin_tracker #(WORD_BITS) board;

	int burst_left    = 0;
	int items_sent    = 0;
	int hold_off_asks = 0;
	int quiet_cycles  = 0;

	spi_master_register_access_core #(.WORD_BITS(WORD_BITS)) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req_ch),
		.res         (res_ch)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic req_t make_req(logic [2:0] mode, logic [6:0] addr, logic [15:0] wdata,
			miso_drive_t drive);
		req_t r;
		r.mode        = mode;
		r.reg_address = addr;
		r.write_data  = wdata;
		case (drive)
			MISO_LOW:  r.miso_level = 1'b0;
			MISO_HIGH: r.miso_level = 1'b1;
			default:   r.miso_level = 1'($urandom);
		endcase
		return r;
	endfunction

	task automatic send_req(input req_t r);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 250) :
				$urandom_range(1, 12);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= r;
		do @(posedge clk); while (!req_ch.ready);
		board.note_request(r);
		items_sent++;
		burst_left--;
	endtask

	task automatic send_cmd(input logic [2:0] mode, input logic [6:0] addr,
			input logic [15:0] wdata, input miso_drive_t drive);
		logic [2:0] noise_mode;
		send_req(make_req(mode, addr, wdata, drive));
		// offer junk commands while the bit sequencer is busy
		while (!board.idle()) begin
			noise_mode = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : MODE_NONE;
			send_req(make_req(noise_mode, 7'($urandom), 16'($urandom), drive));
		end
	endtask

	task automatic set_half(input logic [7:0] ticks_per_half);
		req_ch.valid <= 1'b0;
		burst_left = 0;
		while (board.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= ticks_per_half;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		board.half = ticks_per_half;
	endtask

	task automatic run_traffic(input int target);
		int   stop;
		int   ops;
		logic writing;
		stop = items_sent + target;
		while (items_sent < stop) begin
			if ($urandom_range(0, 9) < 8) begin
				writing = 1'($urandom);
				send_cmd(writing ? MODE_BEGIN_WRITE : MODE_BEGIN_READ, 7'($urandom),
					16'($urandom), MISO_RANDOM);
				ops = $urandom_range(1, 3);
				repeat (ops) begin
					if ($urandom_range(0, 5) == 0) begin
						writing = ~writing;
					end
					if (writing) begin
						send_cmd($urandom_range(0, 1) ? MODE_WRITE_WORD : MODE_WRITE_BYTE,
							7'($urandom), 16'($urandom), MISO_RANDOM);
					end else begin
						send_cmd($urandom_range(0, 1) ? MODE_READ_WORD : MODE_READ_BYTE,
							7'($urandom), 16'($urandom), MISO_RANDOM);
					end
				end
				if ($urandom_range(0, 7) != 0) begin
					send_cmd(MODE_END, 7'($urandom), 16'($urandom), MISO_RANDOM);
				end
			end else begin
				send_cmd(3'($urandom_range(0, 7)), 7'($urandom), 16'($urandom), MISO_RANDOM);
			end
		end
	endtask

	initial begin
		board = new();
		arst_n       <= 1'b0;
		cfg_wr_en    <= 1'b0;
		cfg_wr_data  <= '0;
		req_ch.valid <= 1'b0;
		req_ch.data  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_cmd(MODE_BEGIN_WRITE, 7'h7f, 16'h0000, MISO_RANDOM);
		send_cmd(MODE_WRITE_BYTE, 7'h00, 16'h00ff, MISO_RANDOM);
		send_cmd(MODE_WRITE_WORD, 7'h00, 16'hffff, MISO_RANDOM);
		send_cmd(MODE_WRITE_WORD, 7'h7f, 16'h0000, MISO_RANDOM);
		send_cmd(MODE_WRITE_BYTE, 7'h7f, 16'hff00, MISO_RANDOM);
		send_cmd(MODE_BEGIN_WRITE, 7'h00, 16'h0000, MISO_RANDOM);
		send_cmd(MODE_END, 7'h00, 16'h0000, MISO_RANDOM);
		send_cmd(MODE_END, 7'h00, 16'h0000, MISO_RANDOM);
		send_cmd(MODE_WRITE_WORD, 7'h00, 16'ha5c3, MISO_RANDOM);
		send_cmd(MODE_READ_BYTE, 7'h00, 16'h0000, MISO_HIGH);
		send_cmd(MODE_BEGIN_READ, 7'h2a, 16'h0000, MISO_RANDOM);
		send_cmd(MODE_READ_WORD, 7'h00, 16'h0000, MISO_HIGH);
		send_cmd(MODE_READ_BYTE, 7'h00, 16'h0000, MISO_LOW);
		send_cmd(MODE_READ_WORD, 7'h00, 16'h5a5a, MISO_RANDOM);
		send_cmd(MODE_BEGIN_READ, 7'h55, 16'h0000, MISO_RANDOM);
		send_cmd(MODE_NONE, 7'h00, 16'h0000, MISO_RANDOM);
		send_cmd(MODE_END, 7'h00, 16'h0000, MISO_RANDOM);

		set_half(8'd0);
		hold_off_asks++;
		run_traffic(150);
		set_half(8'd1);
		run_traffic(150);
		set_half(8'd2);
		run_traffic(140);
		set_half(8'($urandom_range(3, 6)));
		run_traffic(80);

		set_half(8'd7);
		send_cmd(MODE_BEGIN_WRITE, 7'($urandom), 16'($urandom), MISO_RANDOM);
		send_cmd(MODE_READ_BYTE, 7'($urandom), 16'($urandom), MISO_RANDOM);
		send_cmd(MODE_END, 7'($urandom), 16'($urandom), MISO_RANDOM);

		set_half(8'($urandom_range(1, 4)));
		run_traffic(80);

		req_ch.valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (board.errors == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

	initial begin
		int cyc;
		int served;
		int hold;
		cyc    = 0;
		served = 0;
		hold   = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready) begin
				board.check_result(res_ch.data);
			end
			cyc++;
			if (hold == 0 && served < hold_off_asks) begin
				served++;
				hold = LONG_HOLD;
			end
			if (hold > 0) begin
				hold--;
				res_ch.ready <= 1'b0;
			end else begin
				case ((cyc / 97) % 4)
					0: res_ch.ready <= 1'b1;
					1: res_ch.ready <= ($urandom_range(0, 3) != 0);
					2: res_ch.ready <= (cyc % 3 == 0);
					default: res_ch.ready <= ($urandom_range(0, 2) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

endmodule

FILE: sim.f
rtl/smra_pkg.sv
rtl/smra_req_if.sv
rtl/smra_res_if.sv
rtl/spi_master_register_access_core.sv
test/tb.sv
